### sv/bcml_pkg.sv
// Package: shared types and constants of the binned colour map lookup.
`timescale 1ns / 1ps
`default_nettype none
package bcml_pkg;
    localparam int MAX_BINS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_COLOR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_MISS   = 2'd1,
        KIND_UNAV   = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    localparam logic [1:0] REG_MISS_VAL  = 2'd0;
    localparam logic [1:0] REG_UNAV_VAL  = 2'd1;
    localparam logic [1:0] REG_MISS_COL  = 2'd2;
    localparam logic [1:0] REG_UNAV_COL  = 2'd3;
endpackage
`default_nettype wire

### sv/bcml_cell.sv
// Bin cell: holds one bin and hands it to its neighbour while the ring rotates.
`timescale 1ns / 1ps
`default_nettype none
module bcml_cell #(
    parameter int VB = bcml_pkg::VALUE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_load,
    input  wire logic          i_shift,
    input  wire logic [VB-1:0] i_lower,
    input  wire logic [VB-1:0] i_upper,
    input  wire logic          i_linear,
    input  wire logic [31:0]   i_col_lo,
    input  wire logic [31:0]   i_col_hi,
    input  wire logic [VB-1:0] i_nb_lower,
    input  wire logic [VB-1:0] i_nb_upper,
    input  wire logic [VB:0]   i_nb_width,
    input  wire logic          i_nb_linear,
    input  wire logic [31:0]   i_nb_col_lo,
    input  wire logic [31:0]   i_nb_col_hi,
    output logic [VB-1:0]      o_lower,
    output logic [VB-1:0]      o_upper,
    output logic [VB:0]        o_width,
    output logic               o_linear,
    output logic [31:0]        o_col_lo,
    output logic [31:0]        o_col_hi
);
    logic [VB-1:0] r_lower, r_upper;
    logic [VB:0]   r_width;
    logic          r_linear;
    logic [31:0]   r_col_lo, r_col_hi;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lower  <= i_lower;
            r_upper  <= i_upper;
            r_width  <= {i_upper[VB-1], i_upper} - {i_lower[VB-1], i_lower};
            r_linear <= i_linear;
            r_col_lo <= i_col_lo;
            r_col_hi <= i_col_hi;
        end else if (i_shift) begin
            r_lower  <= i_nb_lower;
            r_upper  <= i_nb_upper;
            r_width  <= i_nb_width;
            r_linear <= i_nb_linear;
            r_col_lo <= i_nb_col_lo;
            r_col_hi <= i_nb_col_hi;
        end
    end

    assign o_lower  = r_lower;
    assign o_upper  = r_upper;
    assign o_width  = r_width;
    assign o_linear = r_linear;
    assign o_col_lo = r_col_lo;
    assign o_col_hi = r_col_hi;
endmodule
`default_nettype wire

### sv/bcml_interp.sv
// Interpolation unit: one channel per step over four steps, exact rounding.
`timescale 1ns / 1ps
`default_nettype none
module bcml_interp #(
    parameter int VB = bcml_pkg::VALUE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [VB:0]   i_n,
    input  wire logic [VB:0]   i_d,
    input  wire logic [31:0]   i_c0,
    input  wire logic [31:0]   i_c1,
    output logic               o_done,
    output logic [31:0]        o_color,
    output logic               o_clip
);
    import bcml_pkg::*;
    localparam int NW = VB + 12;  // numerator width
    localparam int QW = NW + 1;   // quotient register width
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} t_state;

    t_state          r_state;
    logic [1:0]      r_chan;
    logic [VB:0]     r_n, r_d;
    logic [31:0]     r_c0, r_c1, r_col;
    logic            r_clip, r_done;
    logic [NW-1:0]   r_rem, r_mag;
    logic [NW-1:0]   r_q;
    logic            r_neg;
    logic [$clog2(NW+1)-1:0] r_bit;

    logic [7:0] w_a, w_b;
    logic signed [NW-1:0] w_c0x, w_dx, w_nx, w_dcx;
    logic signed [NW-1:0] w_num;
    logic [NW-1:0] w_trial;
    logic [NW:0]   w_sh;
    logic signed [QW-1:0] w_q;
    logic [7:0]    w_sat;
    logic          w_clp;

    always_comb begin
        w_a   = r_c0[31 - 8*r_chan -: 8];
        w_b   = r_c1[31 - 8*r_chan -: 8];
        // All terms are taken at the full numerator width so no product overflows.
        w_c0x = {{(NW-8){1'b0}}, w_a};
        w_dx  = {{(NW-VB-1){1'b0}}, r_d};
        w_nx  = {{(NW-VB-1){r_n[VB]}}, r_n};
        w_dcx = {{(NW-8){1'b0}}, w_b} - {{(NW-8){1'b0}}, w_a};
        w_num = ((w_c0x * w_dx) <<< 1) + ((w_nx * w_dcx) <<< 1) + w_dx;
        w_sh    = {r_rem, r_mag[NW-1]};
        w_trial = NW'(w_sh - {{(NW-VB-1){1'b0}}, r_d, 1'b0});
        // floor for negatives: -(ceil(|x|/m))
        if (r_neg)
            w_q = -$signed({1'b0, r_q}) - QW'(r_rem != '0);
        else
            w_q = $signed({1'b0, r_q});
        w_clp = 1'b0;
        if (w_q < 0) begin
            w_sat = 8'd0; w_clp = 1'b1;
        end else if (w_q > 255) begin
            w_sat = 8'd255; w_clp = 1'b1;
        end else begin
            w_sat = w_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n <= i_n; r_d <= i_d; r_c0 <= i_c0; r_c1 <= i_c1;
                        r_chan <= 2'd0; r_clip <= 1'b0; r_col <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_neg <= w_num[NW-1];
                    r_mag <= w_num[NW-1] ? NW'(-w_num) : NW'(w_num);
                    r_rem <= '0; r_q <= '0;
                    r_bit <= ($clog2(NW+1))'(NW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit == '0) begin
                        r_col[31 - 8*r_chan -: 8] <= w_sat;
                        r_clip <= r_clip | w_clp;
                        if (r_chan == 2'd3) begin
                            r_done <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_chan <= r_chan + 2'd1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_bit <= r_bit - 1'b1;
                        r_mag <= r_mag << 1;
                        if (w_sh >= {{(NW-VB-1){1'b0}}, r_d, 1'b0}) begin
                            r_rem <= w_trial;
                            r_q   <= {r_q[NW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_sh[NW-1:0];
                            r_q   <= {r_q[NW-2:0], 1'b0};
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_color = r_col;
    assign o_clip  = r_clip;
endmodule
`default_nettype wire

### sv/binned_color_map_lookup.sv
// Top level of the binned colour map lookup.
// The block maps a signed fixed-point data value to an RGBA colour using a
// table of bins loaded through the input channel. Each input transfer
// carries an action: clear the table, append one bin, or colour a value.
// Only colouring transfers give a result on the output channel; clear and
// append finish at their own transfer, so the next one can follow at once.
// The table is a ring of bin cells. A colouring transfer rotates the ring
// once, and the first loaded bin whose upper bound exceeds the value, or
// else the last loaded bin, is captured at cell zero. Solid bins, sentinels
// and an empty table go from the pick state straight to the output.
// Linear bins of nonzero width pass through an interpolation unit
// that handles one channel at a time with a bit-serial divider.
// One item is in flight at a time and the next input transfer can be taken
// in the cycle after the output transfer.
// Configuration registers must be written over the APB port only while
// idle; the block itself does not enforce this.
// Reset clears the bin count and restores the register defaults.
// While the receiver stalls the result is held on the output register and
// no new transfer is accepted until it has been taken.
`timescale 1ns / 1ps
`default_nettype none
module binned_color_map_lookup #(
    parameter int MAX_BINS   = bcml_pkg::MAX_BINS_DEF,
    parameter int VALUE_BITS = bcml_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [1:0]            i_action,
    input  wire logic [VALUE_BITS-1:0] i_data_value,
    input  wire logic                  i_bin_is_linear,
    input  wire logic [VALUE_BITS-1:0] i_bin_lower,
    input  wire logic [VALUE_BITS-1:0] i_bin_upper,
    input  wire logic [31:0]           i_bin_color_low,
    input  wire logic [31:0]           i_bin_color_high,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic [7:0]                 o_alpha,
    output logic [5:0]                 o_chosen_bin,
    output logic [1:0]                 o_value_kind,
    output logic                       o_clipped
);
    import bcml_pkg::*;
    localparam int VB = VALUE_BITS;
    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_INTERP, S_OUT} t_state;

    logic [VB-1:0] r_miss_val, r_unav_val;
    logic [31:0]   r_miss_col, r_unav_col;
    logic [CW-1:0] r_count;
    t_state        r_state;
    logic [VB-1:0] r_value;
    logic [31:0]   r_color;
    logic [IW-1:0] r_bin;
    logic [1:0]    r_kind;
    logic          r_clip;
    logic          r_start;
    logic [VB:0]   r_n, r_d;
    logic [31:0]   r_c0, r_c1;
    logic [IW-1:0] r_step;
    logic          r_found;
    logic [VB-1:0] r_lower;
    logic [VB:0]   r_width;
    logic          r_lin;

    logic                w_wr;
    logic                w_acc;
    logic                w_shift;
    logic                w_take;
    logic [VB-1:0]       w_lower [MAX_BINS];
    logic [VB-1:0]       w_upper [MAX_BINS];
    logic [VB:0]         w_width [MAX_BINS];
    logic                w_lin   [MAX_BINS];
    logic [31:0]         w_clo   [MAX_BINS];
    logic [31:0]         w_chi   [MAX_BINS];
    logic                w_done, w_iclip;
    logic [31:0]         w_icol;
    logic [VB:0]         w_n;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    always_comb begin
        case (paddr[3:2])
            REG_MISS_VAL: prdata = 32'(r_miss_val);
            REG_UNAV_VAL: prdata = 32'(r_unav_val);
            REG_MISS_COL: prdata = r_miss_col;
            default:      prdata = r_unav_col;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid & o_ready;
    assign w_shift = (r_state == S_SCAN);

    // Each cell takes the contents of the next one while the ring rotates, so
    // after a full turn of the ring every bin is back in its own cell.
    genvar g;
    generate
        for (g = 0; g < MAX_BINS; g++) begin : g_cell
            localparam int NB = (g + 1) % MAX_BINS;
            bcml_cell #(.VB(VB)) u_cell (
                .i_clk       (i_clk),
                .i_load      (w_acc && i_action == ACT_APPEND && r_count == CW'(g)),
                .i_shift     (w_shift),
                .i_lower     (i_bin_lower),
                .i_upper     (i_bin_upper),
                .i_linear    (i_bin_is_linear),
                .i_col_lo    (i_bin_color_low),
                .i_col_hi    (i_bin_color_high),
                .i_nb_lower  (w_lower[NB]),
                .i_nb_upper  (w_upper[NB]),
                .i_nb_width  (w_width[NB]),
                .i_nb_linear (w_lin[NB]),
                .i_nb_col_lo (w_clo[NB]),
                .i_nb_col_hi (w_chi[NB]),
                .o_lower     (w_lower[g]),
                .o_upper     (w_upper[g]),
                .o_width     (w_width[g]),
                .o_linear    (w_lin[g]),
                .o_col_lo    (w_clo[g]),
                .o_col_hi    (w_chi[g])
            );
        end
    endgenerate

    // Cell zero holds bin r_step during the scan. The first loaded bin that
    // hits is taken; the last loaded bin is taken if none has hit before it.
    assign w_take = !r_found && (CW'(r_step) < r_count) &&
                    (($signed(w_upper[0]) > $signed(r_value)) ||
                     (CW'(r_step) == r_count - CW'(1)));

    assign w_n = {r_value[VB-1], r_value} - {r_lower[VB-1], r_lower};

    bcml_interp #(.VB(VB)) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_n     (r_n),
        .i_d     (r_d),
        .i_c0    (r_c0),
        .i_c1    (r_c1),
        .o_done  (w_done),
        .o_color (w_icol),
        .o_clip  (w_iclip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_val <= VB'({1'b1, {(VB-1){1'b0}}});
            r_unav_val <= VB'({1'b1, {(VB-2){1'b0}}, 1'b1});
            r_miss_col <= 32'hFF0000FF;
            r_unav_col <= 32'h0000FFFF;
            r_count    <= '0;
            r_state    <= S_IDLE;
            r_start    <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (w_wr) begin
                case (paddr[3:2])
                    REG_MISS_VAL: r_miss_val <= VB'($signed(pwdata));
                    REG_UNAV_VAL: r_unav_val <= VB'($signed(pwdata));
                    REG_MISS_COL: r_miss_col <= pwdata;
                    default:      r_unav_col <= pwdata;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (t_action'(i_action))
                            ACT_CLEAR: r_count <= '0;
                            ACT_APPEND: begin
                                if (r_count < CW'(MAX_BINS))
                                    r_count <= r_count + CW'(1);
                            end
                            ACT_COLOR: begin
                                r_value <= i_data_value;
                                r_step  <= '0;
                                r_found <= 1'b0;
                                r_bin   <= '0;
                                r_state <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_take) begin
                        r_found <= 1'b1;
                        r_bin   <= r_step;
                        r_lower <= w_lower[0];
                        r_width <= w_width[0];
                        r_lin   <= w_lin[0];
                        r_c0    <= w_clo[0];
                        r_c1    <= w_chi[0];
                    end
                    if (r_step == IW'(MAX_BINS - 1))
                        r_state <= S_PICK;
                    else
                        r_step <= r_step + IW'(1);
                end
                S_PICK: begin
                    r_clip <= 1'b0;
                    r_kind <= KIND_DATA;
                    r_state <= S_OUT;
                    if (r_value == r_miss_val) begin
                        r_color <= r_miss_col; r_kind <= KIND_MISS; r_bin <= '0;
                    end else if (r_value == r_unav_val) begin
                        r_color <= r_unav_col; r_kind <= KIND_UNAV; r_bin <= '0;
                    end else if (r_count == '0) begin
                        r_color <= '0; r_kind <= KIND_EMPTY; r_bin <= '0;
                    end else if (!r_lin || r_width == '0) begin
                        r_color <= r_c0;
                    end else begin
                        r_n <= r_width[VB] ? (VB+1)'(0) - w_n : w_n;
                        r_d <= r_width[VB] ? (VB+1)'(0) - r_width : r_width;
                        r_start <= 1'b1;
                        r_state <= S_INTERP;
                    end
                end
                S_INTERP: begin
                    if (w_done) begin
                        r_color <= w_icol;
                        r_clip  <= w_iclip;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = (r_state == S_OUT);
    assign o_red        = r_color[31:24];
    assign o_green      = r_color[23:16];
    assign o_blue       = r_color[15:8];
    assign o_alpha      = r_color[7:0];
    assign o_chosen_bin = 6'(r_bin);
    assign o_value_kind = r_kind;
    assign o_clipped    = r_clip;
endmodule
`default_nettype wire
